>>> design/dns_response_a_record_parser_top_macros.svh
// Assertion macros shared by the DNS reply parser checker.
`ifndef DNS_RESPONSE_A_RECORD_PARSER_TOP_MACROS_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNSARP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNSARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dnsarp_pkg.sv
// Types and constants of the DNS reply A-record parser.
package dnsarp_pkg;

    localparam int DNSARP_POSITION_BITS = 16;

    // Header byte positions that close a 16-bit header field
    localparam int HDR_ID_END    = 1;
    localparam int HDR_FLAGS_END = 3;
    localparam int HDR_QD_END    = 5;
    localparam int HDR_AN_END    = 7;
    localparam int HDR_LAST      = 11;

    localparam logic [7:0]  NAME_PTR_MASK  = 8'hC0;
    localparam logic [7:0]  NAME_END       = 8'h00;
    localparam logic [15:0] QTAIL_LEN      = 16'd4;
    localparam logic [15:0] QTAIL_PTR_LEN  = 16'd5;
    localparam logic [15:0] AFIXED_LEN     = 16'd10;
    localparam logic [15:0] AFIXED_PTR_LEN = 16'd11;
    localparam logic [15:0] AFIXED_TYPE_HI = 16'd10;
    localparam logic [15:0] AFIXED_TYPE_LO = 16'd9;
    localparam logic [15:0] AFIXED_LEN_HI  = 16'd2;
    localparam logic [15:0] AFIXED_LEN_LO  = 16'd1;
    localparam logic [15:0] RR_TYPE_A      = 16'd1;
    localparam logic [15:0] RR_LEN_A       = 16'd4;

    // Result status codes
    localparam logic [2:0] ST_RESOLVED     = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd2;
    localparam logic [2:0] ST_ID_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_RCODE_ERROR  = 3'd4;
    localparam logic [2:0] ST_NO_ANSWERS   = 3'd5;
    localparam logic [2:0] ST_NO_A_RECORD  = 3'd6;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_LABEL  = 3'd2,
        PH_QTAIL  = 3'd3,
        PH_ANAME  = 3'd4,
        PH_AFIXED = 3'd5,
        PH_ARDATA = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        resolved;
        logic [31:0] ipv4_address;
    } out_item_t;

endpackage

>>> design/dns_response_a_record_parser_top.sv
// Top level of the DNS reply A-record parser.
// DNS reply parser: feed the UDP payload of one reply as one byte per item, with
// last_byte set on the final byte; exactly one result item comes back per packet,
// carrying status, resolved and the first IPv4 address of a type A answer whose
// data length is 4. The header must carry QR set, the id held in expected_id, a
// zero rcode and a nonzero answer count; the first failing check, in that order,
// names the status. Packets of fewer than 12 bytes report too short; packets that
// end before a matching A record report no A record. Throughput is one byte per
// cycle while the input is not stalled: each byte passes through an input
// register and a parse-state update, and the result of a final byte lands in an
// output register. A result waiting on a stalled output holds the next packet's
// final byte in the input register, and the input stalls behind it; ordinary
// bytes keep flowing until then.
// Write expected_id only between packets.
module dns_response_a_record_parser_top
    import dnsarp_pkg::*;
#(
    parameter int POSITION_BITS = DNSARP_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        s1_valid_reg, s1_valid_next;
    in_item_t    s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg;
    logic [15:0] expected_id_reg;

    logic      s1_fire;
    logic      accept;
    out_item_t result;

    // Advance the input stage when its byte needs no result slot, or the slot is
    // free or being emptied this cycle.
    assign s1_fire  = s1_valid_reg
                    && (!s1_item_reg.last_byte || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire && s1_item_reg.last_byte)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    dnsarp_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .item        (s1_item_reg),
        .expected_id (expected_id_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            expected_id_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                expected_id_reg <= cfg_wr_data;
        end
    end

    // Payload registers: hold while stalled, load on an accept or a final-byte fire.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= in_item;
        if (s1_fire && s1_item_reg.last_byte)
            out_item_reg <= result;
    end

endmodule

>>> design/dnsarp_parse.sv
// Per-packet parse state and its one-byte update.
module dnsarp_parse
    import dnsarp_pkg::*;
#(
    parameter int POSITION_BITS = DNSARP_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  in_item_t    item,
    input  logic [15:0] expected_id,
    output out_item_t   result
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    phase_t                   phase_reg, phase_next;
    logic [15:0]              header_reg, header_next;
    logic [15:0]              qleft_reg, qleft_next;
    logic [15:0]              aleft_reg, aleft_next;
    logic [15:0]              skip_reg, skip_next;
    logic [15:0]              rtype_reg, rtype_next;
    logic [15:0]              rlen_reg, rlen_next;
    logic [31:0]              acc_reg, acc_next;
    logic [2:0]               verdict_reg, verdict_next;

    logic [7:0]  b;
    logic [15:0] skip_dec;
    logic [15:0] aleft_dec;
    logic [15:0] qleft_dec;
    logic        is_a;

    assign b         = item.data_byte;
    assign skip_dec  = skip_reg - 16'd1;
    assign aleft_dec = aleft_reg - 16'd1;
    assign qleft_dec = qleft_reg - 16'd1;
    assign is_a      = (rtype_reg == RR_TYPE_A) && (rlen_reg == RR_LEN_A);

    // Next state
    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        header_next  = header_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        skip_next    = skip_reg;
        rtype_next   = rtype_reg;
        rlen_next    = rlen_reg;
        acc_next     = acc_reg;
        verdict_next = verdict_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                header_next = {header_reg[7:0], b};
                if (pos_reg == POSITION_BITS'(HDR_ID_END))
                begin
                    verdict_next = (header_next != expected_id) ? ST_ID_MISMATCH : ST_RESOLVED;
                end
                else if (pos_reg == POSITION_BITS'(HDR_FLAGS_END))
                begin
                    if (!header_next[15])
                        verdict_next = ST_NOT_RESPONSE;
                    else if (verdict_reg != ST_ID_MISMATCH && header_next[3:0] != 4'd0)
                        verdict_next = ST_RCODE_ERROR;
                end
                else if (pos_reg == POSITION_BITS'(HDR_QD_END))
                begin
                    qleft_next = header_next;
                end
                else if (pos_reg == POSITION_BITS'(HDR_AN_END))
                begin
                    aleft_next = header_next;
                    if (verdict_reg == ST_RESOLVED && header_next == 16'd0)
                        verdict_next = ST_NO_ANSWERS;
                end
                else if (pos_reg == POSITION_BITS'(HDR_LAST))
                begin
                    if (verdict_reg != ST_RESOLVED)
                        phase_next = PH_DONE;
                    else
                        phase_next = (qleft_reg != 16'd0) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_QNAME:
            begin
                if (b == NAME_END)
                begin
                    phase_next = PH_QTAIL;
                    skip_next  = QTAIL_LEN;
                end
                else if ((b & NAME_PTR_MASK) == NAME_PTR_MASK)
                begin
                    phase_next = PH_QTAIL;
                    skip_next  = QTAIL_PTR_LEN;
                end
                else
                begin
                    phase_next = PH_LABEL;
                    skip_next  = {8'd0, b};
                end
            end
            PH_LABEL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = (qleft_reg != 16'd0) ? PH_QNAME : PH_ANAME;
            end
            PH_QTAIL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    qleft_next = qleft_dec;
                    phase_next = (qleft_dec != 16'd0) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_ANAME:
            begin
                phase_next = PH_AFIXED;
                if (b == NAME_END)
                    skip_next = AFIXED_LEN;
                else if ((b & NAME_PTR_MASK) == NAME_PTR_MASK)
                    skip_next = AFIXED_PTR_LEN;
                else
                begin
                    phase_next = PH_LABEL;
                    skip_next  = {8'd0, b};
                end
            end
            PH_AFIXED:
            begin
                if (skip_reg == AFIXED_TYPE_HI)
                    rtype_next = {b, 8'd0};
                else if (skip_reg == AFIXED_TYPE_LO)
                    rtype_next = {rtype_reg[15:8], b};
                else if (skip_reg == AFIXED_LEN_HI)
                    rlen_next = {b, 8'd0};
                else if (skip_reg == AFIXED_LEN_LO)
                    rlen_next = {rlen_reg[15:8], b};
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (rlen_next == 16'd0)
                    begin
                        // empty record data: this answer is finished
                        aleft_next = aleft_dec;
                        if (aleft_dec == 16'd0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = ST_NO_A_RECORD;
                        end
                        else
                            phase_next = PH_ANAME;
                    end
                    else
                    begin
                        phase_next = PH_ARDATA;
                        skip_next  = rlen_next;
                        acc_next   = 32'd0;
                    end
                end
            end
            PH_ARDATA:
            begin
                if (is_a)
                    acc_next = {acc_reg[23:0], b};
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (is_a)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = ST_RESOLVED;
                    end
                    else
                    begin
                        acc_next   = 32'd0;
                        aleft_next = aleft_dec;
                        if (aleft_dec == 16'd0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = ST_NO_A_RECORD;
                        end
                        else
                            phase_next = PH_ANAME;
                    end
                end
            end
            default:
            begin
                // drop bytes after a decision
            end
        endcase

        if (pos_reg != {POSITION_BITS{1'b1}})
            pos_next = pos_reg + POSITION_BITS'(1);
    end

    // Result for a byte that closes the packet
    always_comb
    begin
        result = '0;
        if (pos_reg < POSITION_BITS'(HDR_LAST))
            result.status = ST_TOO_SHORT;
        else if (phase_next == PH_DONE)
            result.status = verdict_next;
        else
            result.status = ST_NO_A_RECORD;
        result.resolved = (result.status == ST_RESOLVED);
        if (result.resolved)
            result.ipv4_address = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            header_reg  <= '0;
            qleft_reg   <= '0;
            aleft_reg   <= '0;
            skip_reg    <= '0;
            rtype_reg   <= '0;
            rlen_reg    <= '0;
            acc_reg     <= '0;
            verdict_reg <= '0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                pos_reg     <= '0;
                phase_reg   <= PH_HEADER;
                header_reg  <= '0;
                qleft_reg   <= '0;
                aleft_reg   <= '0;
                skip_reg    <= '0;
                rtype_reg   <= '0;
                rlen_reg    <= '0;
                acc_reg     <= '0;
                verdict_reg <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                header_reg  <= header_next;
                qleft_reg   <= qleft_next;
                aleft_reg   <= aleft_next;
                skip_reg    <= skip_next;
                rtype_reg   <= rtype_next;
                rlen_reg    <= rlen_next;
                acc_reg     <= acc_next;
                verdict_reg <= verdict_next;
            end
        end
    end

endmodule

>>> design/dnsarp_checker.sv
// Port-level assertions for the DNS reply parser, bound to its top level.
`include "dns_response_a_record_parser_top_macros.svh"

module dnsarp_checker
    import dnsarp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    `DNSARP_ASSERT_IMPLY(a_resolved_matches_status, clk, rst_n, out_valid, (out_item.resolved == (out_item.status == ST_RESOLVED)), "resolved flag disagrees with status")

    `DNSARP_ASSERT_IMPLY(a_address_zero_unresolved, clk, rst_n, out_valid && !out_item.resolved, (out_item.ipv4_address == 32'd0), "address nonzero on unresolved item")

    `DNSARP_ASSERT_IMPLY(a_status_code_used, clk, rst_n, out_valid, (out_item.status <= ST_NO_A_RECORD), "unused status code on result item")

    `DNSARP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, (out_valid && $stable(out_item)), "stalled result item changed or dropped")

endmodule

bind dns_response_a_record_parser_top dnsarp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
